// File: rtl/bplr_pkg.sv
// bplr_pkg: shared types and constants for the pushbutton press / long-press /
// auto-repeat detector. No dependencies.
package bplr_pkg;

  // Counter and register widths
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_WIDTH   = 16;
  localparam int CMP_WIDTH   = ((COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH) + 1;

  // Configuration register indexes
  localparam logic REG_LONG_THRESHOLD = 1'b0;
  localparam logic REG_REPEAT_PERIOD  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [CFG_WIDTH-1:0] LONG_THRESHOLD_RST = CFG_WIDTH'(100);
  localparam logic [CFG_WIDTH-1:0] REPEAT_PERIOD_RST  = CFG_WIDTH'(20);

  // One input tick
  typedef struct packed {
    logic pin_level;
    logic take_press;
    logic take_long;
    logic take_repeat;
  } item_t;

  // One result
  typedef struct packed {
    logic press_flag;
    logic long_flag;
    logic repeat_flag;
    logic held;
  } result_t;

  // Control between the input stage and the core
  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

endpackage

// File: rtl/bplr_in_stage.sv
// bplr_in_stage: input register for one tick transaction.
// Depends on bplr_pkg.
module bplr_in_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  bplr_pkg::item_t  in_item,
  input  logic             take,
  output bplr_pkg::stage_t stage
);

  logic            valid;
  logic            valid_next;
  bplr_pkg::item_t item;
  logic            load;

  // Full stage stalls unless the core takes it this cycle
  assign in_stall = valid && !take;
  assign load     = in_valid && !in_stall;

  always_comb begin
    valid_next = valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (take) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      item <= in_item;
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

// File: rtl/bplr_core.sv
// bplr_core: configuration registers, detector state and the per-tick update.
// Depends on bplr_pkg.
module bplr_core (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic                               cfg_index,
  input  logic [bplr_pkg::CFG_WIDTH-1:0]     cfg_data,
  input  bplr_pkg::stage_t                   stage,
  input  logic                               out_free,
  output logic                               take,
  output bplr_pkg::result_t                  result
);

  localparam int CW = bplr_pkg::COUNT_WIDTH;
  localparam int MW = bplr_pkg::CMP_WIDTH;

  logic [bplr_pkg::CFG_WIDTH-1:0] long_threshold;
  logic [bplr_pkg::CFG_WIDTH-1:0] repeat_period;

  logic          last_level;
  logic [CW-1:0] hold_count;
  logic [CW-1:0] repeat_phase;
  logic          press_sticky;
  logic          long_sticky;
  logic          repeat_sticky;

  logic          last_level_next;
  logic [CW-1:0] hold_count_next;
  logic [CW-1:0] repeat_phase_next;
  logic          press_sticky_next;
  logic          long_sticky_next;
  logic          repeat_sticky_next;

  logic          lvl;
  logic          press_edge;
  logic [CW-1:0] h0, p0, h1, p1, h2, p2;
  logic [MW-1:0] per_eff;
  logic [MW-1:0] p_inc;
  logic          l1, l2, r2, press1, fire;

  assign take = stage.valid && out_free;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      long_threshold <= bplr_pkg::LONG_THRESHOLD_RST;
      repeat_period  <= bplr_pkg::REPEAT_PERIOD_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        bplr_pkg::REG_LONG_THRESHOLD: long_threshold <= cfg_data;
        bplr_pkg::REG_REPEAT_PERIOD:  repeat_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Per-tick update
  always_comb begin
    lvl        = stage.item.pin_level;
    press_edge = (lvl != last_level) && !lvl;
    per_eff    = (repeat_period == '0) ? MW'(1) : MW'(repeat_period);

    h0 = press_edge ? '0 : hold_count;
    p0 = press_edge ? '0 : repeat_phase;
    p_inc = MW'(p0) + MW'(1);

    // Held: count up (hold saturates), phase wraps at the period
    if (!lvl) begin
      h1 = (h0 == {CW{1'b1}}) ? h0 : h0 + CW'(1);
      p1 = (p_inc >= per_eff) ? '0 : CW'(p_inc);
      l1 = long_sticky;
    end else begin
      h1 = '0;
      p1 = '0;
      l1 = 1'b0;
    end

    press1 = press_sticky || press_edge;
    l2     = l1 || (MW'(h1) > MW'(long_threshold));

    // Retrigger while long-pressed
    fire = (MW'(p1) == per_eff - MW'(1)) && l2;
    r2   = repeat_sticky || fire;
    h2   = fire ? '0 : h1;
    p2   = fire ? '0 : p1;

    result.press_flag  = press1;
    result.long_flag   = l2;
    result.repeat_flag = r2;
    result.held        = !lvl;

    // Take bits clear flags after reporting
    last_level_next    = lvl;
    press_sticky_next  = press1 && !stage.item.take_press;
    long_sticky_next   = l2 && !stage.item.take_long;
    repeat_sticky_next = r2 && !stage.item.take_repeat;
    if (stage.item.take_long && l2) begin
      hold_count_next   = '0;
      repeat_phase_next = '0;
    end else begin
      hold_count_next   = h2;
      repeat_phase_next = p2;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      last_level    <= 1'b1;
      hold_count    <= '0;
      repeat_phase  <= '0;
      press_sticky  <= 1'b0;
      long_sticky   <= 1'b0;
      repeat_sticky <= 1'b0;
    end else if (take) begin
      last_level    <= last_level_next;
      hold_count    <= hold_count_next;
      repeat_phase  <= repeat_phase_next;
      press_sticky  <= press_sticky_next;
      long_sticky   <= long_sticky_next;
      repeat_sticky <= repeat_sticky_next;
    end
  end

endmodule

// File: rtl/bplr_out_stage.sv
// bplr_out_stage: result register holding one result transaction.
// Depends on bplr_pkg.
module bplr_out_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  bplr_pkg::result_t load_data,
  output logic              out_free,
  output logic              out_valid,
  input  logic              out_stall,
  output bplr_pkg::result_t out_data
);

  logic valid_next;

  // Slot is free when empty or being drained this cycle
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    valid_next = out_valid;
    if (load) begin
      valid_next = 1'b1;
    end else if (!out_stall) begin
      valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

// File: rtl/button_press_longpress_repeat.sv
// button_press_longpress_repeat: top level of the pushbutton press / long-press /
// auto-repeat detector. Depends on bplr_pkg, bplr_in_stage, bplr_core, bplr_out_stage.
//
//  channel | ports                                              | handshake
//  --------+----------------------------------------------------+-------------------
//  input   | pin_level, take_press, take_long, take_repeat      | in_valid/in_stall
//  output  | press_flag, long_flag, repeat_flag, held           | out_valid/out_stall
//  config  | cfg_write, cfg_index, cfg_data                     | write enable only
//
// One tick per cycle while the output is not stalled: a transaction is registered
// in the input register, processed by the core once the output slot is free, and
// its result is registered in the output register, which offers it. The core's
// count-and-compare path sets the cycle time.
// Synchronous reset puts the state back to released with all flags clear.
// An output stall holds the result; the input register then fills and stalls.
module button_press_longpress_repeat (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           pin_level,
  input  logic                           take_press,
  input  logic                           take_long,
  input  logic                           take_repeat,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           press_flag,
  output logic                           long_flag,
  output logic                           repeat_flag,
  output logic                           held,
  input  logic                           cfg_write,
  input  logic                           cfg_index,
  input  logic [bplr_pkg::CFG_WIDTH-1:0] cfg_data
);

  bplr_pkg::item_t   in_item;
  bplr_pkg::stage_t  stage;
  bplr_pkg::result_t result;
  bplr_pkg::result_t out_data;
  logic              take;
  logic              out_free;

  assign in_item.pin_level   = pin_level;
  assign in_item.take_press  = take_press;
  assign in_item.take_long   = take_long;
  assign in_item.take_repeat = take_repeat;

  bplr_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .take     (take),
    .stage    (stage)
  );

  bplr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .out_free  (out_free),
    .take      (take),
    .result    (result)
  );

  bplr_out_stage u_out_stage (
    .clk       (clk),
    .rst       (rst),
    .load      (take),
    .load_data (result),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign press_flag  = out_data.press_flag;
  assign long_flag   = out_data.long_flag;
  assign repeat_flag = out_data.repeat_flag;
  assign held        = out_data.held;

endmodule

// File: test/tb_button_press_longpress_repeat.sv
// tb_button_press_longpress_repeat: self-checking testbench for the pushbutton
// press / long-press / auto-repeat detector. Depends on bplr_pkg and the RTL.
// A built-in flag predictor checks every result under varied settings and idling.
module tb_button_press_longpress_repeat;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_stall;
  logic                           pin_level;
  logic                           take_press;
  logic                           take_long;
  logic                           take_repeat;
  logic                           out_valid;
  logic                           out_stall;
  logic                           press_flag;
  logic                           long_flag;
  logic                           repeat_flag;
  logic                           held;
  logic                           cfg_write;
  logic                           cfg_index;
  logic [bplr_pkg::CFG_WIDTH-1:0] cfg_data;

  button_press_longpress_repeat dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .pin_level(pin_level), .take_press(take_press),
    .take_long(take_long), .take_repeat(take_repeat),
    .out_valid(out_valid), .out_stall(out_stall),
    .press_flag(press_flag), .long_flag(long_flag),
    .repeat_flag(repeat_flag), .held(held),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Ticks waiting to be sent, and flag results waiting to come back
  bplr_pkg::item_t   tick_q[$];
  bplr_pkg::result_t flag_q[$];

  // Predictor state and its copy of the registers
  logic                             lvl_m;
  logic [bplr_pkg::COUNT_WIDTH-1:0] hold_m;
  logic [bplr_pkg::COUNT_WIDTH:0]   phase_m;
  logic                             press_m, long_m, rep_m;
  logic [bplr_pkg::CFG_WIDTH-1:0]   thr_m, per_m;

  // Idling controls and the long receiver hold-off request
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned hold_reqs     = 0;
  int unsigned hold_seen     = 0;
  int unsigned hold_left     = 0;

  logic        in_fire;
  int unsigned errors = 0;
  int unsigned n_ticks = 0, n_results = 0, n_settings = 0;
  int unsigned n_press = 0, n_long = 0, n_repeat = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One sample tick of the detector; updates the predictor state
  function automatic bplr_pkg::result_t button_tick(bplr_pkg::item_t it);
    bplr_pkg::result_t              r;
    logic [bplr_pkg::COUNT_WIDTH:0] per_eff;
    per_eff = (per_m == '0) ? (bplr_pkg::COUNT_WIDTH+1)'(1)
                            : (bplr_pkg::COUNT_WIDTH+1)'(per_m);
    if (it.pin_level != lvl_m) begin
      lvl_m = it.pin_level;
      if (!it.pin_level) begin
        press_m = 1'b1;
        hold_m  = '0;
        phase_m = '0;
      end
    end
    if (!it.pin_level) begin
      if (hold_m != '1) hold_m = hold_m + 1'b1;
      phase_m = phase_m + 1'b1;
      if (phase_m >= per_eff) phase_m = '0;
    end else begin
      hold_m  = '0;
      phase_m = '0;
      long_m  = 1'b0;
    end
    if (hold_m > thr_m) long_m = 1'b1;
    // retrigger once per period while long-pressed
    if (phase_m == per_eff - 1'b1 && long_m) begin
      rep_m   = 1'b1;
      hold_m  = '0;
      phase_m = '0;
    end
    r.press_flag  = press_m;
    r.long_flag   = long_m;
    r.repeat_flag = rep_m;
    r.held        = !it.pin_level;
    if (it.take_press) press_m = 1'b0;
    if (it.take_long) begin
      if (long_m) begin
        hold_m  = '0;
        phase_m = '0;
      end
      long_m = 1'b0;
    end
    if (it.take_repeat) rep_m = 1'b0;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic want, input logic got);
    $display("mismatch on result %0d: %s expected %0b got %0b", n_results, field, want, got);
    errors++;
  endtask

  // Driver: new tick offered at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (tick_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        pin_level   <= tick_q[0].pin_level;
        take_press  <= tick_q[0].take_press;
        take_long   <= tick_q[0].take_long;
        take_repeat <= tick_q[0].take_repeat;
        void'(tick_q.pop_front());
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with a counted long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= 300;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor: predict on each accepted tick, check each accepted result
  always @(posedge clk) begin : mon
    bplr_pkg::item_t   tick;
    bplr_pkg::result_t want;
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        tick.pin_level   = pin_level;
        tick.take_press  = take_press;
        tick.take_long   = take_long;
        tick.take_repeat = take_repeat;
        flag_q.push_back(button_tick(tick));
        n_ticks++;
      end
      if (out_valid && !out_stall) begin
        if (flag_q.size() == 0) begin
          $display("unexpected result transaction");
          errors++;
        end else begin
          want = flag_q.pop_front();
          if (press_flag !== want.press_flag)
            report_mismatch("press_flag", want.press_flag, press_flag);
          if (long_flag !== want.long_flag)
            report_mismatch("long_flag", want.long_flag, long_flag);
          if (repeat_flag !== want.repeat_flag)
            report_mismatch("repeat_flag", want.repeat_flag, repeat_flag);
          if (held !== want.held)
            report_mismatch("held", want.held, held);
        end
        n_results++;
        n_press  += press_flag;
        n_long   += long_flag;
        n_repeat += repeat_flag;
      end
    end
  end

  task automatic queue_tick(input logic pin, input logic tp, input logic tl, input logic tr);
    bplr_pkg::item_t it;
    it.pin_level   = pin;
    it.take_press  = tp;
    it.take_long   = tl;
    it.take_repeat = tr;
    tick_q.push_back(it);
  endtask

  // Wait until everything sent has come back, then let the pipeline settle
  task automatic drain_all();
    while (tick_q.size() > 0 || in_valid || flag_q.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [bplr_pkg::CFG_WIDTH-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == bplr_pkg::REG_LONG_THRESHOLD) thr_m = val;
    else per_m = val;
    n_settings++;
  endtask

  // Random take bits, each set about a quarter of the time
  task automatic queue_random_tick(input logic pin);
    queue_tick(pin, $urandom_range(3) == 0, $urandom_range(3) == 0, $urandom_range(3) == 0);
  endtask

  // Mostly well-formed presses with random length; some noise
  task automatic queue_random_phase(input int unsigned count);
    int unsigned queued;
    int unsigned run;
    queued = 0;
    while (queued < count) begin
      if ($urandom_range(99) < 85) begin
        run = $urandom_range(1, 4);
        repeat (run) queue_random_tick(1'b1);
        queued += run;
        run = $urandom_range(1, thr_m + 4 * per_m + 10);
        if (run > 80) run = $urandom_range(1, 80);
        repeat (run) queue_random_tick(1'b0);
        queued += run;
      end else begin
        run = $urandom_range(1, 8);
        repeat (run) queue_random_tick(1'($urandom_range(1)));
        queued += run;
      end
    end
  endtask

  // Run limit
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

  // Main sequence
  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    pin_level   = 1'b1;
    take_press  = 1'b0;
    take_long   = 1'b0;
    take_repeat = 1'b0;
    out_stall   = 1'b0;
    cfg_write   = 1'b0;
    cfg_index   = bplr_pkg::REG_LONG_THRESHOLD;
    cfg_data    = '0;
    lvl_m       = 1'b1;
    hold_m      = '0;
    phase_m     = '0;
    press_m     = 1'b0;
    long_m      = 1'b0;
    rep_m       = 1'b0;
    thr_m       = bplr_pkg::LONG_THRESHOLD_RST;
    per_m       = bplr_pkg::REPEAT_PERIOD_RST;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Default settings: press, takes, release
    queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0);
    queue_tick(1'b0, 1'b1, 1'b1, 1'b1);
    queue_tick(1'b1, 1'b1, 1'b0, 1'b0);
    drain_all();

    // Zero threshold and zero period: long and repeat on every held tick
    write_reg(bplr_pkg::REG_LONG_THRESHOLD, '0);
    write_reg(bplr_pkg::REG_REPEAT_PERIOD, '0);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b0);
    queue_tick(1'b0, 1'b0, 1'b0, 1'b1);
    queue_tick(1'b0, 1'b0, 1'b1, 1'b0);
    queue_tick(1'b0, 1'b1, 1'b0, 1'b1);
    queue_tick(1'b1, 1'b1, 1'b1, 1'b1);
    drain_all();

    // Short threshold and period, then the period lowered mid-count
    write_reg(bplr_pkg::REG_LONG_THRESHOLD, 16'd2);
    write_reg(bplr_pkg::REG_REPEAT_PERIOD, 16'd5);
    repeat (7) queue_tick(1'b0, 1'b0, 1'b0, 1'b0);
    drain_all();
    write_reg(bplr_pkg::REG_REPEAT_PERIOD, 16'd1);
    repeat (3) queue_tick(1'b0, 1'b0, 1'b0, 1'b1);
    queue_tick(1'b0, 1'b1, 1'b1, 1'b1);
    queue_tick(1'b1, 1'b0, 1'b0, 1'b0);
    drain_all();

    // Largest settings: a long hold that never reaches the threshold
    write_reg(bplr_pkg::REG_LONG_THRESHOLD, '1);
    write_reg(bplr_pkg::REG_REPEAT_PERIOD, '1);
    repeat (40) queue_tick(1'b0, 1'b0, 1'b0, 1'b0);
    queue_tick(1'b1, 1'b1, 1'b1, 1'b1);
    drain_all();

    // Random phases across idling modes and settings
    for (int p = 0; p < 8; p++) begin
      write_reg(bplr_pkg::REG_LONG_THRESHOLD, bplr_pkg::CFG_WIDTH'($urandom_range(0, 30)));
      write_reg(bplr_pkg::REG_REPEAT_PERIOD,
                bplr_pkg::CFG_WIDTH'(($urandom_range(9) == 0) ? 0 : $urandom_range(1, 12)));
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 59;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 59;
        end
        default: begin
          send_idle_pct = 26;
          stall_pct     = 26;
        end
      endcase
      queue_random_phase(170);
      // receiver holds off while the sender keeps offering
      if (p == 0) hold_reqs++;
      // sender pauses mid-phase until all results are back
      if (p == 4) begin
        while (tick_q.size() > 85) @(posedge clk);
        begin : pause
          bplr_pkg::item_t rest[$];
          rest = tick_q;
          tick_q.delete();
          drain_all();
          tick_q = rest;
        end
      end
      drain_all();
    end
    send_idle_pct = 0;
    stall_pct     = 0;

    drain_all();
    repeat (20) @(posedge clk);
    $display("covered %0d ticks under %0d register writes, with idle, stall and hold-off phases",
             n_ticks, n_settings);
    $display("results with press %0d, long %0d, repeat %0d; %0d mismatches",
             n_press, n_long, n_repeat, errors);
    if (errors == 0 && flag_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: button_press_longpress_repeat.f
rtl/bplr_pkg.sv
rtl/bplr_in_stage.sv
rtl/bplr_core.sv
rtl/bplr_out_stage.sv
rtl/button_press_longpress_repeat.sv
test/tb_button_press_longpress_repeat.sv
